### src/nsth_pkg.sv
// Shared constants, codes and controller/datapath interface types for the named slot table.
package nsth_pkg;

   // Capacities
   localparam int SLOT_COUNT   = 64;
   localparam int BUCKET_COUNT = 128;
   localparam int NAME_BYTES   = 8;

   // Derived widths
   localparam int SLOT_AW  = $clog2(SLOT_COUNT);
   localparam int LINK_W   = SLOT_AW + 1;
   localparam int BKT_AW   = $clog2(BUCKET_COUNT);
   localparam int KIND_W   = 2;
   localparam int BKT_W    = KIND_W + SLOT_AW;
   localparam int NAME_W   = 8 * NAME_BYTES;
   localparam int BIDX_W   = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
   localparam int BCNT_W   = $clog2(NAME_BYTES + 1);
   localparam int GEN_W    = 16;
   localparam int HASH_W   = 32;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;

   // Stream packing
   localparam int REQ_FIELDS_W = NAME_W + SLOT_AW + GEN_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int REQ_TUSER_W  = MODE_W + 1;
   localparam int RSP_FIELDS_W = SLOT_AW + GEN_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_TUSER_W  = STATUS_W;

   // FNV-1a hash constants
   localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811C_9DC5;
   localparam logic [HASH_W-1:0] FNV_PRIME = 32'h0100_0193;

   typedef enum logic [MODE_W-1:0] {
      MODE_REG     = 2'd0,
      MODE_UNREG   = 2'd1,
      MODE_LOOKUP  = 2'd2,
      MODE_RESOLVE = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_NO_SPACE  = 2'd2,
      ST_BAD       = 2'd3
   } status_type;

   typedef enum logic [KIND_W-1:0] {
      BK_EMPTY = 2'd0,
      BK_TOMB  = 2'd1,
      BK_LIVE  = 2'd2
   } kind_type;

   // Address source for slot store reads
   typedef enum logic [1:0] {
      SEL_SIDX   = 2'd0,
      SEL_HEAD   = 2'd1,
      SEL_BUCKET = 2'd2
   } slot_sel_type;

   // Generation source for a result
   typedef enum logic [1:0] {
      RES_ZERO    = 2'd0,
      RES_GEN     = 2'd1,
      RES_GEN_INC = 2'd2
   } res_src_type;

   typedef struct packed {
      logic         capture;
      logic         hash_step;
      logic         slot_rd;
      slot_sel_type slot_sel;
      logic         probe_init;
      logic         probe_next;
      logic         bucket_rd;
      logic         bucket_tomb;
      logic         reg_commit;
      logic         unreg_commit;
      logic         res_set;
      status_type   res_status;
      res_src_type  res_src;
      logic         rsp_load;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     token;
      logic     hash_done;
      logic     head_none;
      logic     sidx_in_use;
      logic     name_match;
      logic     gen_match;
      kind_type bkt_kind;
      logic     bkt_slot_is_sidx;
      logic     bkt_slot_in_use;
      logic     probe_last;
   } sts_type;

endpackage

### src/named_slot_table_with_hash_index.sv
// Top level of the named slot table: stream ports, controller and datapath.
//
//  channel | direction | tdata                                 | tuser
//  req     | in        | name_key, slot_num, slot_generation   | mode, token_present
//  rsp     | out       | found_slot, found_generation          | status
//
// One request is worked at a time: the beat is taken, a name of L bytes (8 at most) is
// hashed one byte at a time, the slot is checked, each bucket probe reads and then
// evaluates the bucket (with a name compare when a stored name is compared), and the
// result is finished.
// Reset is synchronous; reset state is held in valid bits, so no clearing pass runs.
// A result waits in the output register while the next request is taken.
module named_slot_table_with_hash_index (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // name_key[63:0], slot_num[69:64], slot_generation[85:70], zero pad
   input  logic [nsth_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // mode[1:0], token_present[2]
   input  logic [nsth_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // found_slot[5:0], found_generation[21:6], zero pad
   output logic [nsth_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // status[1:0]
   output logic [nsth_pkg::RSP_TUSER_W-1:0]    rsp_tuser
);
   import nsth_pkg::*;

   cmd_type            cmd;
   sts_type            sts;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_AW-1:0]  rsp_found_slot;
   logic [GEN_W-1:0]    rsp_found_generation;

   nsth_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   nsth_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_mode             (req_tuser[MODE_W-1:0]),
      .req_name_key         (req_tdata[NAME_W-1:0]),
      .req_slot_num         (req_tdata[NAME_W +: SLOT_AW]),
      .req_slot_generation  (req_tdata[NAME_W+SLOT_AW +: GEN_W]),
      .req_token_present    (req_tuser[MODE_W]),
      .cmd                  (cmd),
      .sts                  (sts),
      .rsp_status           (rsp_status),
      .rsp_found_slot       (rsp_found_slot),
      .rsp_found_generation (rsp_found_generation)
   );

   // Pack the result beat
   assign rsp_tdata = {{(RSP_TDATA_W-RSP_FIELDS_W){1'b0}}, rsp_found_generation, rsp_found_slot};
   assign rsp_tuser = rsp_status;

endmodule

### src/nsth_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nsth_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/nsth_dp.sv
// Datapath: request latch, FNV-1a hash, slot and bucket stores, free list and result registers.
module nsth_dp (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic [nsth_pkg::MODE_W-1:0]             req_mode,
   input  logic [nsth_pkg::NAME_W-1:0]             req_name_key,
   input  logic [nsth_pkg::SLOT_AW-1:0]            req_slot_num,
   input  logic [nsth_pkg::GEN_W-1:0]              req_slot_generation,
   input  logic                                    req_token_present,
   input  nsth_pkg::cmd_type                       cmd,
   output nsth_pkg::sts_type                       sts,
   output logic [nsth_pkg::STATUS_W-1:0]           rsp_status,
   output logic [nsth_pkg::SLOT_AW-1:0]            rsp_found_slot,
   output logic [nsth_pkg::GEN_W-1:0]              rsp_found_generation
);
   import nsth_pkg::*;

   // Latched request
   mode_type            mode_ff;
   logic [NAME_W-1:0]   key_ff;
   logic [SLOT_AW-1:0]  sidx_ff;
   logic [GEN_W-1:0]    tgen_ff;
   logic                tok_ff;
   logic [NAME_W-1:0]   key_norm;

   // Hash and probe
   logic [HASH_W-1:0]   hash_ff;
   logic [BCNT_W-1:0]   bcnt_ff;
   logic [7:0]          cur_byte;
   logic [HASH_W-1:0]   hash_mix;
   logic [HASH_W-1:0]   hash_prod;
   logic [BKT_AW-1:0]   probe_ff;
   logic [BKT_AW-1:0]   bkt_addr;

   // Slot state
   logic [LINK_W-1:0]     head_ff;
   logic [SLOT_COUNT-1:0] in_use_ff;
   logic [SLOT_COUNT-1:0] gen_vld_ff;
   logic [SLOT_COUNT-1:0] link_vld_ff;
   logic [BUCKET_COUNT-1:0] bkt_vld_ff;
   logic                  gen_rv_ff;
   logic                  link_rv_ff;
   logic                  bkt_rv_ff;
   logic [SLOT_AW-1:0]    link_ra_ff;
   logic [SLOT_AW-1:0]    cur_slot_ff;
   logic [SLOT_AW-1:0]    slot_addr;

   // Store read data
   logic [GEN_W-1:0]    gen_rd;
   logic [NAME_W-1:0]   name_rd;
   logic [LINK_W-1:0]   link_rd;
   logic [BKT_W-1:0]    bkt_rd;
   logic [GEN_W-1:0]    gen_data;
   logic [GEN_W-1:0]    gen_inc;
   logic [LINK_W-1:0]   link_data;
   kind_type            bkt_kind;
   logic [SLOT_AW-1:0]  bkt_slot;
   logic [BKT_W-1:0]    bkt_wr_data;

   // Results
   status_type          res_status_ff;
   logic [SLOT_AW-1:0]  res_slot_ff;
   logic [GEN_W-1:0]    res_gen_ff;
   status_type          rsp_status_ff;
   logic [SLOT_AW-1:0]  rsp_slot_ff;
   logic [GEN_W-1:0]    rsp_gen_ff;

   // Cut the name at its first zero byte
   always_comb begin
      logic keep;
      keep = 1'b1;
      key_norm = '0;
      for (int i = 0; i < NAME_BYTES; i++) begin
         if (req_name_key[8*i +: 8] == 8'd0) begin
            keep = 1'b0;
         end
         if (keep) begin
            key_norm[8*i +: 8] = req_name_key[8*i +: 8];
         end
      end
   end

   // One hash byte per cycle
   assign cur_byte  = key_ff[8*bcnt_ff[BIDX_W-1:0] +: 8];
   assign hash_mix  = hash_ff ^ {{(HASH_W-8){1'b0}}, cur_byte};
   assign hash_prod = hash_mix * FNV_PRIME;

   assign bkt_addr = hash_ff[BKT_AW-1:0] + probe_ff;

   // Decode store read data, unwritten entries read as reset values
   assign gen_data  = gen_rv_ff ? gen_rd : '0;
   assign gen_inc   = gen_data + GEN_W'(1);
   assign link_data = link_rv_ff ? link_rd : ({1'b0, link_ra_ff} + LINK_W'(1));
   assign bkt_kind  = bkt_rv_ff ? kind_type'(bkt_rd[SLOT_AW +: KIND_W]) : BK_EMPTY;
   assign bkt_slot  = bkt_rd[SLOT_AW-1:0];

   // Pick slot read address
   always_comb begin
      case (cmd.slot_sel)
         SEL_SIDX:   slot_addr = sidx_ff;
         SEL_HEAD:   slot_addr = head_ff[SLOT_AW-1:0];
         SEL_BUCKET: slot_addr = bkt_slot;
         default:    slot_addr = sidx_ff;
      endcase
   end

   assign bkt_wr_data = cmd.reg_commit ? {BK_LIVE, head_ff[SLOT_AW-1:0]}
                                       : {BK_TOMB, bkt_slot};

   nsth_ram #(.WIDTH(GEN_W), .DEPTH(SLOT_COUNT)) u_gen_ram (
      .clock   (clock),
      .wr_en   (cmd.unreg_commit),
      .wr_addr (sidx_ff),
      .wr_data (gen_inc),
      .rd_en   (cmd.slot_rd),
      .rd_addr (slot_addr),
      .rd_data (gen_rd)
   );

   nsth_ram #(.WIDTH(NAME_W), .DEPTH(SLOT_COUNT)) u_name_ram (
      .clock   (clock),
      .wr_en   (cmd.reg_commit),
      .wr_addr (head_ff[SLOT_AW-1:0]),
      .wr_data (key_ff),
      .rd_en   (cmd.slot_rd),
      .rd_addr (slot_addr),
      .rd_data (name_rd)
   );

   nsth_ram #(.WIDTH(LINK_W), .DEPTH(SLOT_COUNT)) u_link_ram (
      .clock   (clock),
      .wr_en   (cmd.unreg_commit),
      .wr_addr (sidx_ff),
      .wr_data (head_ff),
      .rd_en   (cmd.slot_rd && (cmd.slot_sel == SEL_SIDX)),
      .rd_addr (head_ff[SLOT_AW-1:0]),
      .rd_data (link_rd)
   );

   nsth_ram #(.WIDTH(BKT_W), .DEPTH(BUCKET_COUNT)) u_bkt_ram (
      .clock   (clock),
      .wr_en   (cmd.reg_commit || cmd.bucket_tomb),
      .wr_addr (bkt_addr),
      .wr_data (bkt_wr_data),
      .rd_en   (cmd.bucket_rd),
      .rd_addr (bkt_addr),
      .rd_data (bkt_rd)
   );

   // Control state: free list head, use marks, valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         in_use_ff   <= '0;
         gen_vld_ff  <= '0;
         link_vld_ff <= '0;
         bkt_vld_ff  <= '0;
      end else begin
         if (cmd.reg_commit) begin
            head_ff                           <= link_data;
            in_use_ff[head_ff[SLOT_AW-1:0]]   <= 1'b1;
            bkt_vld_ff[bkt_addr]              <= 1'b1;
         end
         if (cmd.bucket_tomb) begin
            bkt_vld_ff[bkt_addr] <= 1'b1;
         end
         if (cmd.unreg_commit) begin
            head_ff              <= {1'b0, sidx_ff};
            in_use_ff[sidx_ff]   <= 1'b0;
            gen_vld_ff[sidx_ff]  <= 1'b1;
            link_vld_ff[sidx_ff] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff     <= mode_type'(req_mode);
         key_ff      <= key_norm;
         sidx_ff     <= req_slot_num;
         tgen_ff     <= req_slot_generation;
         tok_ff      <= req_token_present;
         hash_ff     <= FNV_BASIS;
         bcnt_ff     <= '0;
         cur_slot_ff <= req_slot_num;
      end
      if (cmd.hash_step) begin
         hash_ff <= hash_prod;
         bcnt_ff <= bcnt_ff + BCNT_W'(1);
      end
      if (cmd.probe_init) begin
         probe_ff <= '0;
      end
      if (cmd.probe_next) begin
         probe_ff <= probe_ff + BKT_AW'(1);
      end
      if (cmd.slot_rd) begin
         cur_slot_ff <= slot_addr;
         gen_rv_ff   <= gen_vld_ff[slot_addr];
      end
      if (cmd.slot_rd && (cmd.slot_sel == SEL_SIDX)) begin
         link_ra_ff <= head_ff[SLOT_AW-1:0];
         link_rv_ff <= link_vld_ff[head_ff[SLOT_AW-1:0]];
      end
      if (cmd.bucket_rd) begin
         bkt_rv_ff <= bkt_vld_ff[bkt_addr];
      end
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_status;
         res_slot_ff   <= (cmd.res_src == RES_ZERO) ? '0 : cur_slot_ff;
         case (cmd.res_src)
            RES_GEN:     res_gen_ff <= gen_data;
            RES_GEN_INC: res_gen_ff <= gen_inc;
            default:     res_gen_ff <= '0;
         endcase
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_gen_ff    <= res_gen_ff;
      end
   end

   // Status toward the controller
   always_comb begin
      sts.mode             = mode_ff;
      sts.token            = tok_ff;
      sts.hash_done        = (bcnt_ff == BCNT_W'(NAME_BYTES)) || (cur_byte == 8'd0);
      sts.head_none        = head_ff[LINK_W-1];
      sts.sidx_in_use      = in_use_ff[sidx_ff];
      sts.name_match       = (name_rd == key_ff);
      sts.gen_match        = (gen_data == tgen_ff);
      sts.bkt_kind         = bkt_kind;
      sts.bkt_slot_is_sidx = (bkt_slot == sidx_ff);
      sts.bkt_slot_in_use  = in_use_ff[bkt_slot];
      sts.probe_last       = (probe_ff == BKT_AW'(BUCKET_COUNT - 1));
   end

   assign rsp_status           = rsp_status_ff;
   assign rsp_found_slot       = rsp_slot_ff;
   assign rsp_found_generation = rsp_gen_ff;

endmodule

### src/nsth_ctrl.sv
// Controller: sequences hashing, slot checks, bucket probing and result hand-off.
module nsth_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  nsth_pkg::sts_type sts,
   output nsth_pkg::cmd_type cmd
);
   import nsth_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_HASH,
      S_CHECK,
      S_PROBE_RD,
      S_PROBE_EV,
      S_NAME_EV,
      S_REG_FIN,
      S_UNREG_FIN,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      lookup_path;

   assign lookup_path = (sts.mode == MODE_LOOKUP) ||
                        ((sts.mode == MODE_RESOLVE) && !sts.token);

   // Finish a request with the given status and generation source
   function automatic cmd_type finish(cmd_type c, status_type st, res_src_type src);
      cmd_type r;
      r            = c;
      r.res_set    = 1'b1;
      r.res_status = st;
      r.res_src    = src;
      return r;
   endfunction

   // Next state and commands
   always_comb begin
      cmd          = '0;
      cmd.slot_sel = SEL_SIDX;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_HASH;
            end
         end
         S_HASH: begin
            if (sts.hash_done) begin
               cmd.slot_rd  = 1'b1;
               cmd.slot_sel = SEL_SIDX;
               state_in     = S_CHECK;
            end else begin
               cmd.hash_step = 1'b1;
            end
         end
         S_CHECK: begin
            case (sts.mode)
               MODE_REG: begin
                  if (sts.head_none) begin
                     cmd      = finish(cmd, ST_NO_SPACE, RES_ZERO);
                     state_in = S_DONE;
                  end else begin
                     cmd.probe_init = 1'b1;
                     state_in       = S_PROBE_RD;
                  end
               end
               MODE_UNREG: begin
                  if (!sts.sidx_in_use || !sts.name_match) begin
                     cmd      = finish(cmd, ST_BAD, RES_ZERO);
                     state_in = S_DONE;
                  end else begin
                     cmd.probe_init = 1'b1;
                     state_in       = S_PROBE_RD;
                  end
               end
               default: begin
                  if (lookup_path) begin
                     cmd.probe_init = 1'b1;
                     state_in       = S_PROBE_RD;
                  end else if (!sts.sidx_in_use || !sts.gen_match || !sts.name_match) begin
                     cmd      = finish(cmd, ST_BAD, RES_ZERO);
                     state_in = S_DONE;
                  end else begin
                     cmd      = finish(cmd, ST_OK, RES_GEN);
                     state_in = S_DONE;
                  end
               end
            endcase
         end
         S_PROBE_RD: begin
            cmd.bucket_rd = 1'b1;
            state_in      = S_PROBE_EV;
         end
         S_PROBE_EV: begin
            case (sts.mode)
               MODE_REG: begin
                  if (sts.bkt_kind != BK_LIVE) begin
                     cmd.reg_commit = 1'b1;
                     cmd.slot_rd    = 1'b1;
                     cmd.slot_sel   = SEL_HEAD;
                     state_in       = S_REG_FIN;
                  end else if (sts.probe_last) begin
                     cmd      = finish(cmd, ST_NO_SPACE, RES_ZERO);
                     state_in = S_DONE;
                  end else begin
                     cmd.probe_next = 1'b1;
                     state_in       = S_PROBE_RD;
                  end
               end
               MODE_UNREG: begin
                  if (sts.bkt_kind == BK_EMPTY) begin
                     state_in = S_UNREG_FIN;
                  end else if ((sts.bkt_kind == BK_LIVE) && sts.bkt_slot_is_sidx) begin
                     cmd.bucket_tomb = 1'b1;
                     state_in        = S_UNREG_FIN;
                  end else if (sts.probe_last) begin
                     state_in = S_UNREG_FIN;
                  end else begin
                     cmd.probe_next = 1'b1;
                     state_in       = S_PROBE_RD;
                  end
               end
               default: begin
                  if (sts.bkt_kind == BK_EMPTY) begin
                     cmd      = finish(cmd, ST_NOT_FOUND, RES_ZERO);
                     state_in = S_DONE;
                  end else if ((sts.bkt_kind == BK_LIVE) && sts.bkt_slot_in_use) begin
                     cmd.slot_rd  = 1'b1;
                     cmd.slot_sel = SEL_BUCKET;
                     state_in     = S_NAME_EV;
                  end else if (sts.probe_last) begin
                     cmd      = finish(cmd, ST_NOT_FOUND, RES_ZERO);
                     state_in = S_DONE;
                  end else begin
                     cmd.probe_next = 1'b1;
                     state_in       = S_PROBE_RD;
                  end
               end
            endcase
         end
         S_NAME_EV: begin
            if (sts.name_match) begin
               cmd      = finish(cmd, ST_OK, RES_GEN);
               state_in = S_DONE;
            end else if (sts.probe_last) begin
               cmd      = finish(cmd, ST_NOT_FOUND, RES_ZERO);
               state_in = S_DONE;
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = S_PROBE_RD;
            end
         end
         S_REG_FIN: begin
            cmd      = finish(cmd, ST_OK, RES_GEN);
            state_in = S_DONE;
         end
         S_UNREG_FIN: begin
            cmd.unreg_commit = 1'b1;
            cmd              = finish(cmd, ST_OK, RES_GEN_INC);
            state_in         = S_DONE;
         end
         S_DONE: begin
            // Hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

### sim/tb_named_slot_table_with_hash_index.sv
// Testbench for the named slot table: random and directed requests checked by a scoreboard.
module tb_named_slot_table_with_hash_index;
   import nsth_pkg::*;

   typedef struct {
      status_type  status;
      logic [5:0]  slot;
      logic [15:0] gen;
   } answer_type;

   // Table predictor and queue of expected answers
   class slot_table_scoreboard;
      bit          used [SLOT_COUNT];
      logic [15:0] gens [SLOT_COUNT];
      logic [63:0] names [SLOT_COUNT];
      int          links [SLOT_COUNT];
      int          head;
      kind_type    bkind [BUCKET_COUNT];
      int          bslot [BUCKET_COUNT];
      int          tombs;
      int          live;
      answer_type  pending [$];
      int          errors;

      function void clear();
         for (int i = 0; i < SLOT_COUNT; i++) begin
            used[i] = 0; gens[i] = 0; names[i] = 0; links[i] = i + 1;
         end
         for (int i = 0; i < BUCKET_COUNT; i++) begin
            bkind[i] = BK_EMPTY; bslot[i] = 0;
         end
         head = 0; tombs = 0; live = 0; errors = 0;
      endfunction

      function logic [63:0] trim_name(logic [63:0] k);
         logic [63:0] r;
         r = 0;
         for (int i = 0; i < NAME_BYTES; i++) begin
            if (k[8*i +: 8] == 0) break;
            r[8*i +: 8] = k[8*i +: 8];
         end
         return r;
      endfunction

      function logic [31:0] fnv_hash(logic [63:0] k);
         logic [31:0] h;
         h = 32'h811C_9DC5;
         for (int i = 0; i < NAME_BYTES; i++) begin
            if (k[8*i +: 8] == 0) break;
            h = (h ^ {24'd0, k[8*i +: 8]}) * 32'h0100_0193;
         end
         return h;
      endfunction

      function int find_slot(logic [63:0] nk);
         int b;
         logic [31:0] h;
         h = fnv_hash(nk);
         for (int p = 0; p < BUCKET_COUNT; p++) begin
            b = (h + p) % BUCKET_COUNT;
            if (bkind[b] == BK_EMPTY) return SLOT_COUNT;
            if (bkind[b] == BK_LIVE && used[bslot[b]] && names[bslot[b]] == nk)
               return bslot[b];
         end
         return SLOT_COUNT;
      endfunction

      // Note an accepted request and queue its answer
      function void note_request(mode_type mode, logic [63:0] key, logic [5:0] sidx,
                                 logic [15:0] tgen, logic tok);
         answer_type a;
         logic [63:0] nk;
         logic [31:0] h;
         int s, b;
         bit placed;
         nk = trim_name(key);
         a.status = ST_OK; a.slot = 0; a.gen = 0;
         if (mode == MODE_REG) begin
            if (head >= SLOT_COUNT) a.status = ST_NO_SPACE;
            else begin
               s = head; h = fnv_hash(nk); placed = 0;
               head = links[s]; used[s] = 1; names[s] = nk;
               for (int p = 0; p < BUCKET_COUNT; p++) begin
                  b = (h + p) % BUCKET_COUNT;
                  if (bkind[b] != BK_LIVE) begin
                     if (bkind[b] == BK_TOMB && tombs > 0) tombs--;
                     bkind[b] = BK_LIVE; bslot[b] = s; placed = 1;
                     break;
                  end
               end
               if (!placed) begin
                  used[s] = 0; links[s] = head; head = s; a.status = ST_NO_SPACE;
               end else begin
                  live++; a.slot = s; a.gen = gens[s];
               end
            end
         end else if (mode == MODE_UNREG) begin
            if (!used[sidx] || names[sidx] != nk) a.status = ST_BAD;
            else begin
               h = fnv_hash(nk);
               for (int p = 0; p < BUCKET_COUNT; p++) begin
                  b = (h + p) % BUCKET_COUNT;
                  if (bkind[b] == BK_EMPTY) break;
                  if (bkind[b] == BK_LIVE && bslot[b] == sidx) begin
                     bkind[b] = BK_TOMB; tombs++;
                     break;
                  end
               end
               if (live > 0) live--;
               gens[sidx]++; used[sidx] = 0; links[sidx] = head; head = sidx;
               a.slot = sidx; a.gen = gens[sidx];
            end
         end else if (mode == MODE_LOOKUP || !tok) begin
            s = find_slot(nk);
            if (s >= SLOT_COUNT) a.status = ST_NOT_FOUND;
            else begin
               a.slot = s; a.gen = gens[s];
            end
         end else begin
            if (!used[sidx] || gens[sidx] != tgen || names[sidx] != nk) a.status = ST_BAD;
            else begin
               a.slot = sidx; a.gen = gens[sidx];
            end
         end
         pending.push_back(a);
      endfunction

      // Compare one response beat with the oldest expectation
      function void check_response(logic [1:0] st, logic [5:0] slot, logic [15:0] gen);
         answer_type a;
         if (pending.size() == 0) begin
            $error("unexpected response beat: status %0d slot %0d", st, slot);
            errors++;
            return;
         end
         a = pending.pop_front();
         if (st != a.status) begin
            $error("status: expected %0d, actual %0d", a.status, st); errors++;
         end
         if (slot != a.slot) begin
            $error("found_slot: expected %0d, actual %0d", a.slot, slot); errors++;
         end
         if (gen != a.gen) begin
            $error("found_generation: expected %0d, actual %0d", a.gen, gen); errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   slot_table_scoreboard table_sb;
   bit   calm;          // no idling on either side
   int   hold_cycles;   // receiver hold-off request
   logic [63:0] known_names [$];
   logic [5:0]  live_slots [$];

   named_slot_table_with_hash_index dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   // Send one request beat, idling at random beforehand; valid stays up after the beat
   task automatic send_request(mode_type mode, logic [63:0] key, logic [5:0] sidx,
                               logic [15:0] tgen, logic tok);
      if (!calm && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while (!calm && $urandom_range(99) < 31);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, tgen, sidx, key};
      req_tuser  <= {tok, mode};
      do @(posedge clock); while (!req_tready);
      table_sb.note_request(mode, key, sidx, tgen, tok);
      @(negedge clock);
   endtask

   // Build a short random name, often a reused one
   function automatic logic [63:0] pick_name();
      logic [63:0] k;
      int len;
      if (known_names.size() > 0 && $urandom_range(99) < 60)
         return known_names[$urandom_range(known_names.size() - 1)];
      k = {$urandom, $urandom};
      len = $urandom_range(8);
      if (len < 8) k[8*len +: 8] = 8'h00;
      if (known_names.size() < 24) known_names.push_back(k);
      return k;
   endfunction

   // Drop valid and wait for every expected result
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (table_sb.pending.size() != 0) @(negedge clock);
   endtask

   // Receiver: random stalls, long hold-off when asked
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else rsp_tready <= calm || ($urandom_range(99) >= 31);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         table_sb.check_response(rsp_tuser, rsp_tdata[5:0], rsp_tdata[21:6]);
   end

   initial begin
      #20000000;
      $display("named_slot_table_with_hash_index regression: fail");
      $finish;
   end

   initial begin
      logic [63:0] k;
      int sel;
      table_sb = new();
      table_sb.clear();
      calm = 0; hold_cycles = 0;
      reset = 1'b1; req_tvalid = 1'b0; req_tdata = '0; req_tuser = '0;
      rsp_tready = 1'b0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Directed: empty name, full-length name, all ones, all operations
      send_request(MODE_LOOKUP, 64'd0, 6'd0, 16'd0, 1'b0);
      send_request(MODE_REG, 64'd0, 6'd0, 16'd0, 1'b0);
      send_request(MODE_REG, '1, 6'd63, 16'hFFFF, 1'b1);
      send_request(MODE_REG, 64'h0807060504030201, 6'd0, 16'd0, 1'b0);
      send_request(MODE_REG, 64'h0807060504030201, 6'd0, 16'd0, 1'b0); // duplicate
      send_request(MODE_LOOKUP, 64'hFF00_0000_0000_0041, 6'd0, 16'd0, 1'b0);
      send_request(MODE_RESOLVE, '1, 6'd1, 16'd0, 1'b1);
      send_request(MODE_RESOLVE, '1, 6'd1, 16'd1, 1'b1);   // stale generation
      send_request(MODE_RESOLVE, '1, 6'd63, 16'd0, 1'b1);  // slot not in use
      send_request(MODE_RESOLVE, 64'h0807060504030201, 6'd0, 16'd0, 1'b0);
      send_request(MODE_UNREG, 64'h0807060504030201, 6'd1, 16'd0, 1'b0); // name mismatch
      send_request(MODE_UNREG, 64'h0807060504030201, 6'd2, 16'd0, 1'b0);
      send_request(MODE_UNREG, 64'h0807060504030201, 6'd2, 16'd0, 1'b0); // not in use
      send_request(MODE_REG, 64'h0807060504030201, 6'd0, 16'd0, 1'b0); // reuse tombstone
      send_request(MODE_LOOKUP, 64'h0807060504030201, 6'd0, 16'd0, 1'b0);
      send_request(MODE_UNREG, 64'd0, 6'd0, 16'd0, 1'b0);
      // Fill the table to exhaustion, then report no space
      for (int i = 0; i < 66; i++)
         send_request(MODE_REG, {56'd0, 8'(i + 1)}, 6'd0, 16'd0, 1'b0);
      wait_drained();
      // Free everything so the random part starts from an empty table
      for (int s = 0; s < SLOT_COUNT; s++)
         if (table_sb.used[s]) send_request(MODE_UNREG, table_sb.names[s], 6'(s), 16'd0, 1'b0);

      // Random requests mostly built from live slots, with noise
      for (int n = 0; n < 1600; n++) begin
         if (n == 300) begin
            // Long receiver hold-off while requests keep coming
            hold_cycles = 400;
         end
         if (n == 700) begin
            wait_drained();
            calm = 1;
         end
         if (n == 900) calm = 0;
         live_slots.delete();
         for (int s = 0; s < SLOT_COUNT; s++)
            if (table_sb.used[s]) live_slots.push_back(6'(s));
         sel = $urandom_range(99);
         if (sel < 30 && live_slots.size() < 56) begin
            send_request(MODE_REG, pick_name(), 6'($urandom), 16'($urandom), 1'($urandom));
         end else if (sel < 55 && live_slots.size() > 0) begin
            int s;
            s = live_slots[$urandom_range(live_slots.size() - 1)];
            k = table_sb.names[s];
            if ($urandom_range(3) == 0) k = pick_name();
            send_request(MODE_UNREG, k, 6'(s), 16'($urandom), 1'($urandom));
         end else if (sel < 75) begin
            send_request(MODE_LOOKUP, pick_name(), 6'($urandom), 16'($urandom),
                         1'($urandom));
         end else if (live_slots.size() > 0) begin
            int s;
            logic [15:0] g;
            s = live_slots[$urandom_range(live_slots.size() - 1)];
            g = table_sb.gens[s];
            if ($urandom_range(4) == 0) g = 16'($urandom);
            send_request(MODE_RESOLVE, table_sb.names[s], 6'(s), g, 1'($urandom_range(9) > 0));
         end else begin
            send_request(MODE_RESOLVE, pick_name(), 6'($urandom), 16'($urandom),
                         1'($urandom));
         end
      end

      wait_drained();
      repeat (40) @(negedge clock);
      if (table_sb.errors == 0 && table_sb.pending.size() == 0)
         $display("named_slot_table_with_hash_index regression: pass");
      else
         $display("named_slot_table_with_hash_index regression: fail");
      $finish;
   end
endmodule
